[src/ftsh_pkg.sv]
// Package for the fiducial target selector: field widths, reason codes, item kinds,
// the queued item struct, and table lookup helpers. No dependencies.
`default_nettype none
package ftsh_pkg;
  localparam int MarkerSlots = 4;
  localparam int MaxDetections = 256;
  localparam int CntW = $clog2(MaxDetections + 1);
  localparam int EntryW = 59;

  localparam logic [1:0] KIND_DET = 2'd0;
  localparam logic [1:0] KIND_LAST = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [3:0] R_NONE = 4'd0;
  localparam logic [3:0] R_ACQUIRE = 4'd1;
  localparam logic [3:0] R_HOLD = 4'd2;
  localparam logic [3:0] R_MISSING = 4'd3;
  localparam logic [3:0] R_CLEARED = 4'd4;
  localparam logic [3:0] R_AREA_LOW = 4'd5;
  localparam logic [3:0] R_NEAR_BORDER = 4'd6;
  localparam logic [3:0] R_STABILIZING = 4'd7;
  localparam logic [3:0] R_SWITCH = 4'd8;

  localparam logic [2:0] REG_ENTRY_0 = 3'd0;
  localparam logic [2:0] REG_ENTRY_1 = 3'd1;
  localparam logic [2:0] REG_ENTRY_2 = 3'd2;
  localparam logic [2:0] REG_ENTRY_3 = 3'd3;
  localparam logic [2:0] REG_HOLD = 3'd4;
  localparam logic [2:0] REG_BORDER = 3'd5;
  localparam logic [2:0] REG_SWITCH = 3'd6;
  localparam logic [2:0] REG_GRACE = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] id;
    logic [23:0] area;
    logic [15:0] border;
    logic [7:0] index;
  } item_t;

  typedef struct packed {
    logic hit;
    logic [15:0] len;
    logic [7:0] prio;
    logic [23:0] min_area;
  } entry_t;

  typedef struct packed {
    logic v;
    logic [9:0] id;
    logic [23:0] area;
    logic [15:0] border;
    logic [7:0] index;
  } hit_t;

  function automatic entry_t lookup(input logic [MarkerSlots*EntryW-1:0] tbl,
                                    input logic [9:0] id);
    entry_t e;
    logic [EntryW-1:0] w;
    e = '0;
    for (int s = MarkerSlots - 1; s >= 0; s--) begin
      w = tbl[s*EntryW +: EntryW];
      if (w[0] && w[10:1] == id) begin
        e.hit = 1'b1;
        e.len = w[26:11];
        e.prio = w[34:27];
        e.min_area = w[58:35];
      end
    end
    return e;
  endfunction

  function automatic logic better(input hit_t a, input entry_t ea,
                                  input hit_t b, input entry_t eb);
    if (ea.len != eb.len) return ea.len > eb.len;
    if (ea.prio != eb.prio) return ea.prio < eb.prio;
    if (a.area != b.area) return a.area > b.area;
    if (a.id != b.id) return a.id < b.id;
    return a.index < b.index;
  endfunction
endpackage
`default_nettype wire

[src/ftsh_queue.sv]
// Two-entry queue between the front (accept) and back (selection) parts.
// Depends on ftsh_pkg.
`default_nettype none
module ftsh_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire ftsh_pkg::item_t wdata,
  output logic                full,
  input  wire logic           rd,
  output logic                nonempty,
  output ftsh_pkg::item_t     rdata
);
  ftsh_pkg::item_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full = cnt == 2'd2;
  assign nonempty = cnt != 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

[src/ftsh_back.sv]
// Back part: running bests per detection and the frame-end hysteresis decision.
// Depends on ftsh_pkg.
`default_nettype none
module ftsh_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [ftsh_pkg::MarkerSlots*ftsh_pkg::EntryW-1:0] tbl,
  input  wire logic [8:0]            hold_ratio,
  input  wire logic [15:0]           border_margin,
  input  wire logic [7:0]            switch_frames,
  input  wire logic [7:0]            grace_frames,
  input  wire logic                  in_valid,
  input  wire ftsh_pkg::item_t       item,
  output logic                       in_take,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output ftsh_pkg::hit_t             o_sel,
  output logic                       o_act_v,
  output logic [9:0]                 o_act_id,
  output logic                       o_ch_v,
  output logic [9:0]                 o_ch_id,
  output logic [7:0]                 o_ch_n,
  output logic [3:0]                 o_reason,
  output logic                       o_changed
);
  logic act_f, ch_f;
  logic [9:0] act_m, ch_m;
  logic [8:0] miss;
  logic [7:0] ch_n;
  ftsh_pkg::hit_t ba, bo;
  logic [ftsh_pkg::CntW-1:0] fcnt;

  logic act_f_n, ch_f_n, changed;
  logic [9:0] act_m_n, ch_m_n;
  logic [8:0] miss_n;
  logic [7:0] ch_n_n;
  ftsh_pkg::hit_t ba_n, bo_n, h, sel, act, chal;
  ftsh_pkg::entry_t e, eba, ebo, ea, ec;
  logic [3:0] reason, degraded;
  logic single, fin, done;
  logic [9:0] single_id;
  logic [2:0] nvalid;
  logic [32:0] lhs, rhs;

  // an item completes when no result is pending or the pending one leaves
  assign in_take = in_valid && (!out_valid || !out_stall);

  always_comb begin
    nvalid = '0;
    single_id = '0;
    for (int s = 0; s < ftsh_pkg::MarkerSlots; s++)
      if (tbl[s*ftsh_pkg::EntryW]) begin
        nvalid = nvalid + 3'd1;
        single_id = tbl[s*ftsh_pkg::EntryW + 1 +: 10];
      end
    single = nvalid == 3'd1;

    h.v = 1'b1;
    h.id = item.id;
    h.area = item.area;
    h.border = item.border;
    h.index = item.index;
    e = ftsh_pkg::lookup(tbl, item.id);
    eba = ftsh_pkg::lookup(tbl, ba.id);
    ebo = ftsh_pkg::lookup(tbl, bo.id);
    ba_n = ba;
    bo_n = bo;
    if ((item.kind == ftsh_pkg::KIND_DET || item.kind == ftsh_pkg::KIND_LAST) &&
        fcnt < ftsh_pkg::CntW'(ftsh_pkg::MaxDetections) && item.area != '0 && e.hit) begin
      if (single) begin
        if (item.id == single_id && (!ba.v || !eba.hit || ftsh_pkg::better(h, e, ba, eba)))
          ba_n = h;
      end else if (act_f && item.id == act_m) begin
        if (!ba.v || !eba.hit || ftsh_pkg::better(h, e, ba, eba)) ba_n = h;
      end else if (item.area >= e.min_area && item.border >= border_margin) begin
        if (!bo.v || !ebo.hit || ftsh_pkg::better(h, e, bo, ebo)) bo_n = h;
      end
    end

    // frame-end decision on the updated bests
    act_f_n = act_f; act_m_n = act_m; miss_n = miss;
    ch_f_n = ch_f; ch_m_n = ch_m; ch_n_n = ch_n;
    sel = '0; reason = ftsh_pkg::R_NONE; changed = 1'b0; done = 1'b0;
    degraded = ftsh_pkg::R_MISSING;
    act = ba_n; chal = bo_n;
    ea = ftsh_pkg::lookup(tbl, act_m);
    ec = ftsh_pkg::lookup(tbl, bo_n.id);
    lhs = {1'b0, act.area, 8'd0};
    rhs = 33'(ea.min_area) * 33'(hold_ratio);
    if (single) begin
      done = 1'b1;
      ch_f_n = 1'b0; ch_m_n = '0; ch_n_n = '0;
      if (act.v) begin
        changed = !act_f || act_m != single_id;
        sel = act; sel.id = single_id;
        act_f_n = 1'b1; act_m_n = single_id; miss_n = '0;
        reason = changed ? ftsh_pkg::R_ACQUIRE : ftsh_pkg::R_HOLD;
      end else if (act_f) begin
        if (miss != 9'd511) miss_n = miss + 9'd1;
        if (miss_n > {1'b0, grace_frames}) begin
          act_f_n = 1'b0; act_m_n = '0; miss_n = '0;
          reason = ftsh_pkg::R_CLEARED; changed = 1'b1;
        end else reason = ftsh_pkg::R_MISSING;
      end
    end else if (!act_f) begin
      done = 1'b1;
      ch_f_n = 1'b0; ch_m_n = '0; ch_n_n = '0;
      if (chal.v && ec.hit) begin
        act_f_n = 1'b1; act_m_n = chal.id; miss_n = '0;
        sel = chal; reason = ftsh_pkg::R_ACQUIRE; changed = 1'b1;
      end
    end else begin
      if (act.v && !ea.hit) act.v = 1'b0;
      act.id = act_m;
      if (chal.v && !ec.hit) chal.v = 1'b0;
      if (!act.v) begin
        if (miss != 9'd511) miss_n = miss + 9'd1;
      end else begin
        miss_n = '0;
        if (lhs < rhs) degraded = ftsh_pkg::R_AREA_LOW;
        else if (act.border <= border_margin) degraded = ftsh_pkg::R_NEAR_BORDER;
        else if (!chal.v || ec.len <= ea.len) begin
          done = 1'b1;
          ch_f_n = 1'b0; ch_m_n = '0; ch_n_n = '0;
          sel = act; reason = ftsh_pkg::R_HOLD;
        end
      end
      if (!done) begin
        if (chal.v) begin
          if (ch_f && ch_m == chal.id) begin
            if (ch_n != 8'd255) ch_n_n = ch_n + 8'd1;
          end else begin
            ch_f_n = 1'b1; ch_m_n = chal.id; ch_n_n = 8'd1;
          end
          if (ch_n_n >= switch_frames) begin
            act_m_n = chal.id; miss_n = '0;
            ch_f_n = 1'b0; ch_m_n = '0; ch_n_n = '0;
            sel = chal; reason = ftsh_pkg::R_SWITCH; changed = 1'b1;
          end else begin
            sel = act; reason = ftsh_pkg::R_STABILIZING;
          end
        end else begin
          ch_f_n = 1'b0; ch_m_n = '0; ch_n_n = '0;
          if (!act.v && miss_n > {1'b0, grace_frames}) begin
            act_f_n = 1'b0; act_m_n = '0; miss_n = '0;
            reason = ftsh_pkg::R_CLEARED; changed = 1'b1;
          end else begin
            sel = act; reason = degraded;
          end
        end
      end
    end
    if (!sel.v) sel = '0;
    fin = item.kind == ftsh_pkg::KIND_LAST || item.kind == ftsh_pkg::KIND_END;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_f <= 1'b0; act_m <= '0; miss <= '0;
      ch_f <= 1'b0; ch_m <= '0; ch_n <= '0;
      ba <= '0; bo <= '0; fcnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_take && fin) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (in_take) begin
        if (item.kind == ftsh_pkg::KIND_CLEAR) begin
          act_f <= 1'b0; act_m <= '0; miss <= '0;
          ch_f <= 1'b0; ch_m <= '0; ch_n <= '0;
          ba <= '0; bo <= '0; fcnt <= '0;
        end else if (item.kind == ftsh_pkg::KIND_DET) begin
          ba <= ba_n; bo <= bo_n;
          if (fcnt < ftsh_pkg::CntW'(ftsh_pkg::MaxDetections)) fcnt <= fcnt + 1'b1;
        end else begin
          act_f <= act_f_n; act_m <= act_m_n; miss <= miss_n;
          ch_f <= ch_f_n; ch_m <= ch_m_n; ch_n <= ch_n_n;
          ba <= '0; bo <= '0; fcnt <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && fin) begin
      o_sel <= sel;
      o_act_v <= act_f_n;
      o_act_id <= act_f_n ? act_m_n : 10'd0;
      o_ch_v <= ch_f_n;
      o_ch_id <= ch_f_n ? ch_m_n : 10'd0;
      o_ch_n <= ch_n_n;
      o_reason <= reason;
      o_changed <= changed;
    end
  end
endmodule
`default_nettype wire

[src/fiducial_target_selector_hysteresis_top.sv]
// Fiducial target selector top: config registers, front queue, back selector.
// A frame-end beat is accepted into the queue, taken from it by the back part, and its
// result is registered as the back part takes it. Throughput: one item per cycle; the back
// part takes one a cycle while its result register is free or draining. Synchronous
// active-high reset clears state and loads register defaults.
// Depends on ftsh_pkg, ftsh_queue, ftsh_back.
`default_nettype none
module fiducial_target_selector_hysteresis_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [58:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [9:0]  marker_id,
  input  wire logic [23:0] corner_area,
  input  wire logic [15:0] border_distance,
  input  wire logic [7:0]  det_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             selected_valid,
  output logic [9:0]       selected_id,
  output logic [23:0]      selected_area,
  output logic [15:0]      selected_border,
  output logic [7:0]       selected_index,
  output logic             active_valid,
  output logic [9:0]       active_marker_id,
  output logic             challenger_valid,
  output logic [9:0]       challenger_id,
  output logic [7:0]       challenger_frames,
  output logic [3:0]       reason,
  output logic             target_changed
);
  logic [ftsh_pkg::MarkerSlots*ftsh_pkg::EntryW-1:0] tbl;
  logic [8:0] hold_ratio;
  logic [15:0] border_margin;
  logic [7:0] switch_frames, grace_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl <= '0;
      hold_ratio <= 9'd256;
      border_margin <= '0;
      switch_frames <= 8'd1;
      grace_frames <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ftsh_pkg::REG_ENTRY_0, ftsh_pkg::REG_ENTRY_1, ftsh_pkg::REG_ENTRY_2,
        ftsh_pkg::REG_ENTRY_3: begin
          tbl[cfg_index[1:0]*ftsh_pkg::EntryW +: ftsh_pkg::EntryW] <= cfg_data;
        end
        ftsh_pkg::REG_HOLD: hold_ratio <= cfg_data[8:0];
        ftsh_pkg::REG_BORDER: border_margin <= cfg_data[15:0];
        ftsh_pkg::REG_SWITCH: switch_frames <= cfg_data[7:0];
        ftsh_pkg::REG_GRACE: grace_frames <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ftsh_pkg::item_t wdata, rdata;
  logic full, nonempty, take;
  ftsh_pkg::hit_t sel;

  assign wdata = '{kind: kind, id: marker_id, area: corner_area,
                   border: border_distance, index: det_index};
  assign in_stall = full;

  ftsh_queue u_queue (
    .clk(clk), .rst(rst), .wr(in_valid && !full), .wdata(wdata), .full(full),
    .rd(take), .nonempty(nonempty), .rdata(rdata)
  );

  ftsh_back u_back (
    .clk(clk), .rst(rst), .tbl(tbl), .hold_ratio(hold_ratio),
    .border_margin(border_margin), .switch_frames(switch_frames),
    .grace_frames(grace_frames), .in_valid(nonempty), .item(rdata), .in_take(take),
    .out_valid(out_valid), .out_stall(out_stall), .o_sel(sel),
    .o_act_v(active_valid), .o_act_id(active_marker_id), .o_ch_v(challenger_valid),
    .o_ch_id(challenger_id), .o_ch_n(challenger_frames), .o_reason(reason),
    .o_changed(target_changed)
  );

  assign selected_valid = sel.v;
  assign selected_id = sel.id;
  assign selected_area = sel.area;
  assign selected_border = sel.border;
  assign selected_index = sel.index;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(reason)) else $error("result lost");
  a_sel: assert property (@(posedge clk) disable iff (rst)
    out_valid && !selected_valid |-> selected_id == 10'd0) else $error("stale id");
  a_chg: assert property (@(posedge clk) disable iff (rst)
    out_valid && target_changed |-> reason == ftsh_pkg::R_ACQUIRE ||
    reason == ftsh_pkg::R_SWITCH || reason == ftsh_pkg::R_CLEARED) else $error("bad change");
endmodule
`default_nettype wire

[dv/fiducial_target_selector_hysteresis_top_test.sv]
// Self-checking testbench for the fiducial target selector with hysteresis.
// Drives detection beats through a random-gap driver, predicts each frame-end
// result in a local model, and compares it beat by beat. Depends on ftsh_pkg.
`timescale 1ns / 1ps
module fiducial_target_selector_hysteresis_top_test;

  typedef struct packed {
    logic       sv;
    logic [9:0] sid;
    logic [23:0] sarea;
    logic [15:0] sborder;
    logic [7:0] sindex;
    logic       av;
    logic [9:0] aid;
    logic       cv;
    logic [9:0] cid;
    logic [7:0] cframes;
    logic [3:0] rsn;
    logic       chg;
  } frame_res_t;

  typedef struct {
    logic       ok;
    logic [15:0] len;
    logic [7:0] prio;
    logic [23:0] min_area;
  } slot_info_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [58:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = '0;
  logic [9:0] marker_id = '0;
  logic [23:0] corner_area = '0;
  logic [15:0] border_distance = '0;
  logic [7:0] det_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic selected_valid, active_valid, challenger_valid, target_changed;
  logic [9:0] selected_id, active_marker_id, challenger_id;
  logic [23:0] selected_area;
  logic [15:0] selected_border;
  logic [7:0] selected_index, challenger_frames;
  logic [3:0] reason;

  fiducial_target_selector_hysteresis_top dut (.*);

  // predictor state
  logic [58:0] tbl [4];
  int unsigned m_hold, m_border, m_switch, m_grace;
  logic m_act; logic [9:0] m_act_id; int unsigned m_miss;
  logic m_ch; logic [9:0] m_ch_id; int unsigned m_ch_cnt;
  ftsh_pkg::hit_t best_act, best_oth;
  int unsigned det_cnt;

  ftsh_pkg::item_t pending [$];
  frame_res_t expected_frames [$];
  int errors = 0;
  int frames_seen = 0;
  int unsigned cycle = 0;
  int accepted = 0;
  int gap_in = 0, gap_out = 0;
  logic in_taken = 1'b0;
  int reason_hits [9];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 2000000) begin
      $display("fiducial_target_selector_hysteresis_top_test NOT OK");
      $finish;
    end
  end

  function automatic slot_info_t find_slot(logic [9:0] id);
    slot_info_t e;
    e.ok = 0; e.len = 0; e.prio = 0; e.min_area = 0;
    for (int s = 0; s < 4; s++)
      if (!e.ok && tbl[s][0] && tbl[s][10:1] == id) begin
        e.ok = 1; e.len = tbl[s][26:11]; e.prio = tbl[s][34:27];
        e.min_area = tbl[s][58:35];
      end
    return e;
  endfunction

  function automatic int live_slots(output logic [9:0] last_id);
    int n = 0;
    last_id = 0;
    for (int s = 0; s < 4; s++)
      if (tbl[s][0]) begin n++; last_id = tbl[s][10:1]; end
    return n;
  endfunction

  function automatic logic outranks(ftsh_pkg::hit_t a, slot_info_t ea,
                                    ftsh_pkg::hit_t b, slot_info_t eb);
    if (ea.len != eb.len) return ea.len > eb.len;
    if (ea.prio != eb.prio) return ea.prio < eb.prio;
    if (a.area != b.area) return a.area > b.area;
    if (a.id != b.id) return a.id < b.id;
    return a.index < b.index;
  endfunction

  task automatic keep_best(inout ftsh_pkg::hit_t best, input ftsh_pkg::hit_t h,
                           input slot_info_t eh);
    slot_info_t eb;
    eb = find_slot(best.id);
    if (!best.v || !eb.ok || outranks(h, eh, best, eb)) best = h;
  endtask

  function automatic void drop_challenger();
    m_ch = 0; m_ch_id = 0; m_ch_cnt = 0;
  endfunction

  function automatic frame_res_t pack_res(ftsh_pkg::hit_t sel, logic [3:0] r, logic c);
    frame_res_t o;
    o.sv = sel.v;
    o.sid = sel.v ? sel.id : '0;
    o.sarea = sel.v ? sel.area : '0;
    o.sborder = sel.v ? sel.border : '0;
    o.sindex = sel.v ? sel.index : '0;
    o.av = m_act; o.aid = m_act ? m_act_id : '0;
    o.cv = m_ch; o.cid = m_ch ? m_ch_id : '0;
    o.cframes = m_ch_cnt[7:0]; o.rsn = r; o.chg = c;
    return o;
  endfunction

  task automatic take_det(ftsh_pkg::item_t it);
    ftsh_pkg::hit_t h;
    slot_info_t e;
    logic [9:0] sid;
    logic single;
    single = live_slots(sid) == 1;
    if (det_cnt >= ftsh_pkg::MaxDetections) return;
    det_cnt++;
    h = '{v: 1'b1, id: it.id, area: it.area, border: it.border, index: it.index};
    e = find_slot(h.id);
    if (h.area == 0 || !e.ok) return;
    if (single) begin
      if (h.id == sid) keep_best(best_act, h, e);
      return;
    end
    if (m_act && h.id == m_act_id) begin
      keep_best(best_act, h, e);
      return;
    end
    if (h.area >= e.min_area && h.border >= m_border) keep_best(best_oth, h, e);
  endtask

  function automatic frame_res_t close_frame();
    ftsh_pkg::hit_t act, chal, none;
    slot_info_t ea, ec;
    logic [9:0] sid;
    logic [3:0] degraded;
    logic chg;
    act = best_act; chal = best_oth; none = '0; degraded = ftsh_pkg::R_MISSING;
    if (live_slots(sid) == 1) begin
      if (act.v) begin
        chg = !m_act || m_act_id != sid;
        act.id = sid; m_act = 1; m_act_id = sid; m_miss = 0; drop_challenger();
        return pack_res(act, chg ? ftsh_pkg::R_ACQUIRE : ftsh_pkg::R_HOLD, chg);
      end
      drop_challenger();
      if (!m_act) return pack_res(none, ftsh_pkg::R_NONE, 0);
      if (m_miss < 511) m_miss++;
      if (m_miss > m_grace) begin
        m_act = 0; m_act_id = 0; m_miss = 0;
        return pack_res(none, ftsh_pkg::R_CLEARED, 1);
      end
      return pack_res(none, ftsh_pkg::R_MISSING, 0);
    end
    if (!m_act) begin
      drop_challenger();
      ec = find_slot(chal.id);
      if (!chal.v || !ec.ok) return pack_res(none, ftsh_pkg::R_NONE, 0);
      m_act = 1; m_act_id = chal.id; m_miss = 0;
      return pack_res(chal, ftsh_pkg::R_ACQUIRE, 1);
    end
    ea = find_slot(m_act_id);
    if (act.v && !ea.ok) act.v = 0;
    act.id = m_act_id;
    ec = find_slot(chal.id);
    if (chal.v && !ec.ok) chal.v = 0;
    if (!act.v) begin
      if (m_miss < 511) m_miss++;
    end else begin
      m_miss = 0;
      if (64'(act.area) * 256 < 64'(ea.min_area) * m_hold) degraded = ftsh_pkg::R_AREA_LOW;
      else if (act.border <= m_border) degraded = ftsh_pkg::R_NEAR_BORDER;
      else if (!chal.v || ec.len <= ea.len) begin
        drop_challenger();
        return pack_res(act, ftsh_pkg::R_HOLD, 0);
      end
    end
    if (chal.v) begin
      if (m_ch && m_ch_id == chal.id) begin
        if (m_ch_cnt < 255) m_ch_cnt++;
      end else begin
        m_ch = 1; m_ch_id = chal.id; m_ch_cnt = 1;
      end
      if (m_ch_cnt >= m_switch) begin
        m_act_id = chal.id; m_miss = 0; drop_challenger();
        return pack_res(chal, ftsh_pkg::R_SWITCH, 1);
      end
      return pack_res(act, ftsh_pkg::R_STABILIZING, 0);
    end
    drop_challenger();
    if (!act.v && m_miss > m_grace) begin
      m_act = 0; m_act_id = 0; m_miss = 0;
      return pack_res(none, ftsh_pkg::R_CLEARED, 1);
    end
    return pack_res(act, degraded, 0);
  endfunction

  task automatic predict(ftsh_pkg::item_t it);
    if (it.kind == ftsh_pkg::KIND_CLEAR) begin
      m_act = 0; m_act_id = 0; m_miss = 0; drop_challenger();
      best_act = '0; best_oth = '0; det_cnt = 0;
      return;
    end
    if (it.kind != ftsh_pkg::KIND_END) take_det(it);
    if (it.kind == ftsh_pkg::KIND_DET) return;
    expected_frames.push_back(close_frame());
    best_act = '0; best_oth = '0; det_cnt = 0;
  endtask

  task automatic present(ftsh_pkg::item_t it);
    in_valid <= 1'b1;
    kind <= it.kind; marker_id <= it.id;
    corner_area <= it.area; border_distance <= it.border;
    det_index <= it.index;
  endtask

  // input side: a beat is taken at the rising edge with valid high and stall low
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict(pending.pop_front());
      accepted++;
      in_taken = 1'b1;
    end
  end

  // driver: one beat per pending item, random gaps between beats
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        in_taken = 1'b0;
        gap_in = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 9)) : 0;
        if (gap_in == 0 && pending.size() > 0) present(pending[0]);
        else in_valid <= 1'b0;
      end else if (!in_valid) begin
        if (gap_in > 0) gap_in--;
        if (gap_in == 0 && pending.size() > 0) present(pending[0]);
      end
      if (gap_out > 0) begin
        out_stall <= 1'b1; gap_out--;
      end else out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    frame_res_t got, exp_r;
    if (!rst && out_valid && !out_stall) begin
      got = '{selected_valid, selected_id, selected_area, selected_border, selected_index,
              active_valid, active_marker_id, challenger_valid, challenger_id,
              challenger_frames, reason, target_changed};
      frames_seen <= frames_seen + 1;
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_frames.pop_front();
        if (exp_r.rsn < 9) reason_hits[exp_r.rsn]++;
        if (got !== exp_r) begin
          $display("%0t: mismatch exp sv=%0d id=%0d ar=%0d bd=%0d ix=%0d av=%0d aid=%0d",
                   $time, exp_r.sv, exp_r.sid, exp_r.sarea, exp_r.sborder, exp_r.sindex,
                   exp_r.av, exp_r.aid);
          $display("        exp cv=%0d cid=%0d cf=%0d rsn=%0d chg=%0d", exp_r.cv,
                   exp_r.cid, exp_r.cframes, exp_r.rsn, exp_r.chg);
          $display("        act sv=%0d id=%0d ar=%0d bd=%0d ix=%0d av=%0d aid=%0d",
                   got.sv, got.sid, got.sarea, got.sborder, got.sindex, got.av, got.aid);
          $display("        act cv=%0d cid=%0d cf=%0d rsn=%0d chg=%0d", got.cv, got.cid,
                   got.cframes, got.rsn, got.chg);
          errors++;
        end
      end
      gap_out = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [58:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    if (idx <= ftsh_pkg::REG_ENTRY_3) tbl[idx[1:0]] = val;
    else if (idx == ftsh_pkg::REG_HOLD) m_hold = val[8:0];
    else if (idx == ftsh_pkg::REG_BORDER) m_border = val[15:0];
    else if (idx == ftsh_pkg::REG_SWITCH) m_switch = val[7:0];
    else m_grace = val[7:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected_frames.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [58:0] make_entry(logic v, logic [9:0] id, logic [15:0] len,
                                             logic [7:0] prio, logic [23:0] mina);
    return {mina, prio, len, id, v};
  endfunction

  function automatic ftsh_pkg::item_t rand_det(logic [1:0] k, logic [9:0] ids [4]);
    ftsh_pkg::item_t it;
    it.kind = k;
    it.id = ($urandom_range(0, 7) == 0) ? 10'($urandom) : ids[$urandom_range(0, 3)];
    case ($urandom_range(0, 5))
      0: it.area = 0;
      1: it.area = 24'hFFFFFF;
      2: it.area = 24'($urandom);
      default: it.area = 24'($urandom_range(0, 4000));
    endcase
    it.border = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    it.index = 8'($urandom);
    return it;
  endfunction

  initial begin
    logic [9:0] ids [4];
    ftsh_pkg::item_t it;
    int nslots;
    m_hold = 256; m_border = 0; m_switch = 1; m_grace = 0;
    for (int s = 0; s < 4; s++) tbl[s] = '0;
    m_act = 0; m_act_id = 0; m_miss = 0; drop_challenger();
    best_act = '0; best_oth = '0; det_cnt = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // empty table: every frame reports none valid
    pending.push_back('{ftsh_pkg::KIND_LAST, 10'd5, 24'd100, 16'd10, 8'd0});
    pending.push_back('{ftsh_pkg::KIND_END, 10'd0, 24'd0, 16'd0, 8'd0});
    drain();

    // directed: four markers, field extremes, clear, removal of active
    write_reg(ftsh_pkg::REG_ENTRY_0, make_entry(1, 10'd0, 16'd100, 8'd1, 24'd50));
    write_reg(ftsh_pkg::REG_ENTRY_1, make_entry(1, 10'd1023, 16'd200, 8'd0, 24'd0));
    write_reg(ftsh_pkg::REG_ENTRY_2, make_entry(1, 10'd7, 16'd200, 8'd255, 24'hFFFFFF));
    write_reg(ftsh_pkg::REG_ENTRY_3, make_entry(1, 10'd0, 16'd300, 8'd0, 24'd1));
    write_reg(ftsh_pkg::REG_HOLD, 59'd256);
    write_reg(ftsh_pkg::REG_BORDER, 59'd0);
    write_reg(ftsh_pkg::REG_SWITCH, 59'd2);
    write_reg(ftsh_pkg::REG_GRACE, 59'd1);
    pending.push_back('{ftsh_pkg::KIND_DET, 10'd0, 24'd60, 16'd5, 8'd0});
    pending.push_back('{ftsh_pkg::KIND_DET, 10'd1023, 24'hFFFFFF, 16'hFFFF, 8'd255});
    pending.push_back('{ftsh_pkg::KIND_LAST, 10'd0, 24'd0, 16'd3, 8'd1});
    pending.push_back('{ftsh_pkg::KIND_LAST, 10'd1023, 24'd1, 16'd1, 8'd0});
    pending.push_back('{ftsh_pkg::KIND_LAST, 10'd7, 24'hFFFFFF, 16'hFFFF, 8'd2});
    pending.push_back('{ftsh_pkg::KIND_LAST, 10'd7, 24'hFFFFFF, 16'hFFFF, 8'd3});
    pending.push_back('{ftsh_pkg::KIND_END, 10'd0, 24'd0, 16'd0, 8'd0});
    pending.push_back('{ftsh_pkg::KIND_END, 10'd0, 24'd0, 16'd0, 8'd0});
    pending.push_back('{ftsh_pkg::KIND_END, 10'd0, 24'd0, 16'd0, 8'd0});
    pending.push_back('{ftsh_pkg::KIND_DET, 10'd1023, 24'd9, 16'd9, 8'd9});
    pending.push_back('{ftsh_pkg::KIND_CLEAR, 10'd0, 24'd0, 16'd0, 8'd0});
    pending.push_back('{ftsh_pkg::KIND_END, 10'd0, 24'd0, 16'd0, 8'd0});
    pending.push_back('{ftsh_pkg::KIND_LAST, 10'd0, 24'd80, 16'd9, 8'd4});
    drain();
    // active marker dropped from the table shows as missing
    write_reg(ftsh_pkg::REG_ENTRY_0, '0);
    write_reg(ftsh_pkg::REG_ENTRY_3, '0);
    pending.push_back('{ftsh_pkg::KIND_END, 10'd0, 24'd0, 16'd0, 8'd0});
    pending.push_back('{ftsh_pkg::KIND_LAST, 10'd0, 24'd80, 16'd9, 8'd5});
    // more than MaxDetections in one frame: the tail is ignored
    for (int i = 0; i < 258; i++)
      pending.push_back('{(i == 257) ? ftsh_pkg::KIND_LAST : ftsh_pkg::KIND_DET, 10'd1023,
                         24'(i + 1), 16'd0, 8'(i)});
    drain();

    // random phases with varied settings
    for (int ph = 0; ph < 10; ph++) begin
      for (int s = 0; s < 4; s++) ids[s] = 10'($urandom_range(0, 15));
      nslots = 0;
      for (int s = 0; s < 4; s++) begin
        logic v;
        v = (ph % 4 == 1) ? (s == 2) : ($urandom_range(0, 4) != 0);
        write_reg(3'(s), make_entry(v, ids[s], 16'($urandom_range(0, 3) * (ph % 3 == 0 ?
                  16'd20000 : 16'd1)), 8'($urandom), (ph % 3 == 2) ?
                  24'($urandom) : 24'($urandom_range(0, 3000))));
      end
      write_reg(ftsh_pkg::REG_HOLD, (ph == 0) ? 59'd1 : (ph == 3) ? 59'd0 :
                (ph == 5) ? 59'h1FF : 59'($urandom_range(1, 256)));
      write_reg(ftsh_pkg::REG_BORDER, (ph == 2) ? 59'hFFFF : 59'($urandom_range(0, 200)));
      write_reg(ftsh_pkg::REG_SWITCH, (ph == 4) ? 59'd0 : (ph == 6) ? 59'd255 :
                59'($urandom_range(1, 4)));
      write_reg(ftsh_pkg::REG_GRACE, (ph == 7) ? 59'd255 : 59'($urandom_range(0, 3)));
      for (int i = 0; i < 52; i++) begin
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) it = '{ftsh_pkg::KIND_CLEAR, 10'($urandom), 24'($urandom),
                           16'($urandom), 8'($urandom)};
        else if (r < 4) it = rand_det(ftsh_pkg::KIND_END, ids);
        else if (r < 10) it = rand_det(ftsh_pkg::KIND_LAST, ids);
        else it = rand_det(ftsh_pkg::KIND_DET, ids);
        pending.push_back(it);
      end
      drain();
    end

    $display("covered %0d items, %0d frame results; reasons none..switch: %0d %0d %0d %0d %0d",
             accepted, frames_seen, reason_hits[0], reason_hits[1], reason_hits[2],
             reason_hits[3], reason_hits[4]);
    $display("  area low %0d, near border %0d, stabilizing %0d, switch %0d",
             reason_hits[5], reason_hits[6], reason_hits[7], reason_hits[8]);
    if (errors == 0 && expected_frames.size() == 0)
      $display("fiducial_target_selector_hysteresis_top_test OK");
    else
      $display("fiducial_target_selector_hysteresis_top_test NOT OK");
    $finish;
  end
endmodule

[sim.f]
src/ftsh_pkg.sv
src/ftsh_queue.sv
src/ftsh_back.sv
src/fiducial_target_selector_hysteresis_top.sv
dv/fiducial_target_selector_hysteresis_top_test.sv
